// ===== rtl/hpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpsd_pkg : shared constants for the straight-run heading controller
// Field widths, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package hpsd_pkg;

  // field widths
  localparam int COUNT_BITS = 20;
  localparam int DRIVE_BITS = 8;
  localparam int HEAD_W     = 13;
  localparam int TIME_W     = 20;
  localparam int GAIN_W     = 16;
  localparam int TDIST_W    = 24;
  localparam int SPEED_W    = 16;
  localparam int INTEG_W    = 48;

  // stream packing
  localparam int IN_DATA_W   = HEAD_W + 2 * COUNT_BITS + TIME_W;
  localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 2 * DRIVE_BITS;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_HEAD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_DIST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DRIVE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIVE = 3'd7;

  // fixed-point constants
  localparam int HALF_TURN   = 2880;
  localparam int FULL_TURN   = 5760;
  localparam int START_SPEED = 25600;
  localparam int RAMP_STEP   = 333;
  localparam int STOP_SPEED  = 2560;
  localparam int MICROS      = 1000000;

  // serial arithmetic units
  localparam int MUL_W   = 64;
  localparam int MUL_B_W = 20;
  localparam int DIV_W   = 64;
  localparam int REM_W   = 20;

endpackage

// ===== rtl/heading_pid_straight_drive.sv =====
// ----------------------------------------------------------------------------
// heading_pid_straight_drive : straight-run PID heading controller
// Ramps the run speed, wraps the heading error and steers two wheels.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_*: tuser is the kind (0 start run, 1 control tick), tdata
//   carries heading, right and left pulse counts and elapsed microseconds.
//   Output stream m_*: one item per input item; tdata holds the two wheel
//   drives, tuser shows the run as active, tlast marks the tick ending it.
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// Sequence
//   A start item or an idle tick goes from the decide step straight to the
//   output step. An active tick runs five passes of a shift-add multiplier,
//   two passes of a restoring divider and 13 single steps. One item is in
//   work at a time; s_tready is high only between items.
// Reset
//   rst clears the run state, the integral and the previous error and loads
//   the register defaults. A stalled result stays in the output register;
//   the next item may be taken meanwhile but waits to deliver until the
//   register is free.
// ----------------------------------------------------------------------------
module heading_pid_straight_drive
  import hpsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata: heading, right_pulses, left_pulses, elapsed_us (lowest bit up)
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // tuser: kind
  input  logic                   s_tuser,
  // result items
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata: left_drive, right_drive (lowest bit up)
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // tuser: running
  output logic                   m_tuser,
  // tlast: run_done
  output logic                   m_tlast,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SUM_W  = COUNT_BITS + 1;
  localparam int DIST_W = COUNT_BITS + 16;
  localparam int DMAG_W = 50;
  localparam int C_W    = 56;
  localparam int W_W    = 58;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DECIDE = 5'd1;
  localparam logic [4:0] ST_MUL    = 5'd2;
  localparam logic [4:0] ST_DIV    = 5'd3;
  localparam logic [4:0] ST_GAP    = 5'd4;
  localparam logic [4:0] ST_RAMP   = 5'd5;
  localparam logic [4:0] ST_ERR    = 5'd6;
  localparam logic [4:0] ST_D2     = 5'd7;
  localparam logic [4:0] ST_D3     = 5'd8;
  localparam logic [4:0] ST_D4     = 5'd9;
  localparam logic [4:0] ST_INT    = 5'd10;
  localparam logic [4:0] ST_I2     = 5'd11;
  localparam logic [4:0] ST_I3     = 5'd12;
  localparam logic [4:0] ST_SUM    = 5'd13;
  localparam logic [4:0] ST_WHEEL  = 5'd14;
  localparam logic [4:0] ST_OUT    = 5'd15;

  // configuration registers
  logic [GAIN_W-1:0]     gain_p, gain_i, gain_d, distance_per_pulse;
  logic [HEAD_W-1:0]     target_heading;
  logic [TDIST_W-1:0]    target_distance;
  logic [7:0]            min_drive, max_drive;

  // run state
  logic [SPEED_W-1:0]    ramp_speed;
  logic [INTEG_W-1:0]    error_integral;
  logic [HEAD_W-1:0]     previous_error;
  logic                  run_active;

  // sequencer
  logic [4:0]            state, ret_state;

  // latched item
  logic                  kind_r;
  logic [HEAD_W-1:0]     heading_r;
  logic [COUNT_BITS-1:0] rp_r, lp_r;
  logic [TIME_W-1:0]     dt_r;

  // shift-add multiplier
  logic [MUL_W-1:0]      mul_a, acc;
  logic [MUL_B_W-1:0]    mul_b;
  logic [4:0]            mul_cnt;

  // restoring divider
  logic [DIV_W-1:0]      div_q;
  logic [REM_W-1:0]      div_d, div_rem;
  logic [5:0]            div_cnt;
  logic [REM_W:0]        div_t;

  // intermediate values
  logic [DIST_W-1:0]     gap;
  logic                  dist_ge, done_r;
  logic [HEAD_W-1:0]     e_r;
  logic                  e_neg, diff_neg, int_neg;
  logic [11:0]           e_mag;
  logic signed [29:0]    pe;
  logic [DMAG_W-1:0]     d_mag;
  logic signed [C_W-1:0] c_r;

  // result register
  logic [DRIVE_BITS-1:0] res_left, res_right;
  logic                  res_running, res_done;
  logic [DRIVE_BITS-1:0] out_left, out_right;

  // combinational helpers
  logic signed [15:0]      h16, t16, e16, e_wrap, diff16;
  logic [31:0]             gap100, s35;
  logic                    near;
  logic [SPEED_W-1:0]      ramp_new;
  logic [32:0]             p4;
  logic signed [INTEG_W:0] p4s, isum;
  logic [INTEG_W-1:0]      int_sat, int_mag;
  logic signed [C_W-1:0]   d_s, i_s;
  logic signed [W_W-1:0]   base, lo, hi, wl, wr, wl_c, wr_c;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = OUT_TDATA_W'({out_right, out_left});

  // clamp of a wheel value; below min wins over above max
  function automatic logic signed [W_W-1:0] clamp_w(
    input logic signed [W_W-1:0] w,
    input logic signed [W_W-1:0] l,
    input logic signed [W_W-1:0] u
  );
    logic signed [W_W-1:0] r;
    if (w < l) r = l;
    else if (w > u) r = u;
    else r = w;
    return r;
  endfunction

  // heading error and ramp decisions
  always_comb begin
    h16 = (heading_r > HEAD_W'(HALF_TURN)) ? $signed({3'b0, heading_r}) - 16'sd5760
                                           : $signed({3'b0, heading_r});
    t16 = 16'(signed'(target_heading));
    e16 = t16 - h16;
    if (e16 > 16'sd2880) e_wrap = e16 - 16'sd5760;
    else if (e16 < -16'sd2880) e_wrap = e16 + 16'sd5760;
    else e_wrap = e16;
    diff16 = 16'(signed'(e_wrap[HEAD_W-1:0])) - 16'(signed'(previous_error));

    gap100 = 32'(gap[23:0]) * 32'd100;
    s35    = 32'(target_distance) * 32'd35;
    near   = (gap[DIST_W-1:24] == '0) && (gap100 < s35);
    if (near) ramp_new = (ramp_speed >= SPEED_W'(RAMP_STEP)) ?
                         ramp_speed - SPEED_W'(RAMP_STEP) : '0;
    else ramp_new = ramp_speed;

    p4   = acc[32:0];
    p4s  = e_neg ? -$signed({16'b0, p4}) : $signed({16'b0, p4});
    isum = $signed({error_integral[INTEG_W-1], error_integral}) + p4s;
    if (isum[INTEG_W] != isum[INTEG_W-1])
      int_sat = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    else
      int_sat = isum[INTEG_W-1:0];
    int_mag = error_integral[INTEG_W-1] ? -error_integral : error_integral;

    d_s = diff_neg ? -$signed(C_W'(d_mag)) : $signed(C_W'(d_mag));
    i_s = int_neg ? -$signed(C_W'(div_q[47:0])) : $signed(C_W'(div_q[47:0]));

    base = $signed({{(W_W-20){1'b0}}, ramp_speed, 4'b0});
    lo   = $signed({{(W_W-20){1'b0}}, min_drive, 12'b0});
    hi   = $signed({{(W_W-20){1'b0}}, max_drive, 12'b0});
    wl   = base + W_W'(c_r);
    wr   = base - W_W'(c_r);
    wl_c = clamp_w(wl, lo, hi);
    wr_c = clamp_w(wr, lo, hi);

    div_t = {div_rem, div_q[DIV_W-1]};
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p             <= 16'd883;
      gain_i             <= 16'd23;
      gain_d             <= 16'd256;
      target_heading     <= '0;
      target_distance    <= '0;
      distance_per_pulse <= 16'd1024;
      min_drive          <= 8'd0;
      max_drive          <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_P:    gain_p             <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:    gain_i             <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:    gain_d             <= cfg_data[GAIN_W-1:0];
        CFG_TGT_HEAD:  target_heading     <= cfg_data[HEAD_W-1:0];
        CFG_TGT_DIST:  target_distance    <= cfg_data[TDIST_W-1:0];
        CFG_DIST_PP:   distance_per_pulse <= cfg_data[GAIN_W-1:0];
        CFG_MIN_DRIVE: min_drive          <= cfg_data[7:0];
        CFG_MAX_DRIVE: max_drive          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      out_left  <= res_left;
      out_right <= res_right;
      m_tuser   <= res_running;
      m_tlast   <= res_done;
    end
  end

  // sequencer with control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ramp_speed     <= '0;
      error_integral <= '0;
      previous_error <= '0;
      run_active     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!kind_r) begin
            ramp_speed <= SPEED_W'(START_SPEED);
            run_active <= (target_distance != '0);
            state      <= ST_OUT;
          end else if (!run_active) begin
            state <= ST_OUT;
          end else begin
            state     <= ST_MUL;
            ret_state <= ST_GAP;
          end
        end
        ST_MUL: begin
          if (mul_cnt == 5'(MUL_B_W - 1)) state <= ret_state;
        end
        ST_DIV: begin
          if (div_cnt == 6'(DIV_W - 1)) state <= ret_state;
        end
        ST_GAP:  state <= ST_RAMP;
        ST_RAMP: begin
          ramp_speed <= ramp_new;
          state      <= ST_ERR;
        end
        ST_ERR: begin
          state     <= ST_MUL;
          ret_state <= ST_D2;
        end
        ST_D2: begin
          state     <= ST_MUL;
          ret_state <= ST_D3;
        end
        ST_D3: begin
          state     <= ST_DIV;
          ret_state <= ST_D4;
        end
        ST_D4: begin
          state     <= ST_MUL;
          ret_state <= ST_INT;
        end
        ST_INT: begin
          error_integral <= int_sat;
          state          <= ST_I2;
        end
        ST_I2: begin
          state     <= ST_MUL;
          ret_state <= ST_I3;
        end
        ST_I3: begin
          state     <= ST_DIV;
          ret_state <= ST_SUM;
        end
        ST_SUM:  state <= ST_WHEEL;
        ST_WHEEL: begin
          previous_error <= e_r;
          run_active     <= !done_r;
          state          <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: item latch, serial units and per-step values
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        kind_r    <= s_tuser;
        heading_r <= s_tdata[HEAD_W-1:0];
        rp_r      <= s_tdata[HEAD_W +: COUNT_BITS];
        lp_r      <= s_tdata[HEAD_W+COUNT_BITS +: COUNT_BITS];
        dt_r      <= s_tdata[HEAD_W+2*COUNT_BITS +: TIME_W];
      end
      ST_DECIDE: begin
        res_left    <= '0;
        res_right   <= '0;
        res_done    <= 1'b0;
        res_running <= !kind_r ? (target_distance != '0) : 1'b0;
        // distance product: pulse sum by travel per pulse
        mul_a   <= MUL_W'(SUM_W'(lp_r) + SUM_W'(rp_r));
        mul_b   <= MUL_B_W'(distance_per_pulse);
        acc     <= '0;
        mul_cnt <= '0;
      end
      ST_MUL: begin
        if (mul_b[0]) acc <= acc + mul_a;
        mul_a   <= {mul_a[MUL_W-2:0], 1'b0};
        mul_b   <= {1'b0, mul_b[MUL_B_W-1:1]};
        mul_cnt <= mul_cnt + 5'd1;
      end
      ST_DIV: begin
        if (div_t >= {1'b0, div_d}) begin
          div_rem <= REM_W'(div_t - {1'b0, div_d});
          div_q   <= {div_q[DIV_W-2:0], 1'b1};
        end else begin
          div_rem <= div_t[REM_W-1:0];
          div_q   <= {div_q[DIV_W-2:0], 1'b0};
        end
        div_cnt <= div_cnt + 6'd1;
      end
      ST_GAP: begin
        dist_ge <= acc[DIST_W:1] >= DIST_W'(target_distance);
        gap     <= (acc[DIST_W:1] >= DIST_W'(target_distance)) ?
                   acc[DIST_W:1] - DIST_W'(target_distance) :
                   DIST_W'(target_distance) - acc[DIST_W:1];
      end
      ST_RAMP: begin
        done_r <= dist_ge || (ramp_new <= SPEED_W'(STOP_SPEED));
      end
      ST_ERR: begin
        e_r      <= e_wrap[HEAD_W-1:0];
        e_neg    <= e_wrap[15];
        e_mag    <= e_wrap[15] ? 12'(-e_wrap) : e_wrap[11:0];
        diff_neg <= diff16[15];
        // derivative: gain by error change
        mul_a    <= MUL_W'(gain_d);
        mul_b    <= MUL_B_W'(diff16[15] ? HEAD_W'(-diff16) : diff16[HEAD_W-1:0]);
        acc      <= '0;
        mul_cnt  <= '0;
      end
      ST_D2: begin
        pe      <= $signed({1'b0, gain_p}) * $signed(e_r);
        mul_a   <= acc;
        mul_b   <= MUL_B_W'(MICROS);
        acc     <= '0;
        mul_cnt <= '0;
      end
      ST_D3: begin
        div_q   <= acc;
        div_d   <= REM_W'(dt_r);
        div_rem <= '0;
        div_cnt <= '0;
      end
      ST_D4: begin
        d_mag   <= (dt_r == '0) ? '0 : div_q[DMAG_W-1:0];
        // integral increment: error by elapsed time
        mul_a   <= MUL_W'(e_mag);
        mul_b   <= MUL_B_W'(dt_r);
        acc     <= '0;
        mul_cnt <= '0;
      end
      ST_I2: begin
        int_neg <= error_integral[INTEG_W-1];
        mul_a   <= MUL_W'(int_mag);
        mul_b   <= MUL_B_W'(gain_i);
        acc     <= '0;
        mul_cnt <= '0;
      end
      ST_I3: begin
        div_q   <= acc;
        div_d   <= REM_W'(MICROS);
        div_rem <= '0;
        div_cnt <= '0;
      end
      ST_SUM: begin
        c_r <= C_W'(pe) + d_s + i_s;
      end
      ST_WHEEL: begin
        res_left    <= DRIVE_BITS'(wl_c[19:12]);
        res_right   <= DRIVE_BITS'(wr_c[19:12]);
        res_running <= !done_r;
        res_done    <= done_r;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/hpsd_checker.sv =====
// ----------------------------------------------------------------------------
// hpsd_checker : port-level checks for the straight-run controller
// Watches the result stream and binds to the top level.
// ----------------------------------------------------------------------------
module hpsd_checker
  import hpsd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic                   m_tuser,
  input logic                   m_tlast
);

  // the ending item never shows the run as still active
  a_done_not_running: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tuser)
    else $error("run_done item shows running");

  // outside a run and not ending one, both drives are zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser && !m_tlast) |-> (m_tdata == '0))
    else $error("drive nonzero outside a run");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind heading_pid_straight_drive hpsd_checker u_hpsd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : testbench for the straight-run heading controller
// Runs of start and tick items are streamed in, with random idling on both
// sides. Each result is checked against a cycle-free model of the steering
// arithmetic. Registers are rewritten between phases, with extremes included.
// ----------------------------------------------------------------------------
module tb;
  import hpsd_pkg::*;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct {
    logic              kind;
    logic [HEAD_W-1:0] heading;
    logic [19:0]       right_pulses;
    logic [19:0]       left_pulses;
    logic [19:0]       elapsed_us;
  } drive_item_t;

  typedef struct {
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic       running;
    logic       run_done;
  } drive_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  heading_pid_straight_drive DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies and controller state of the model
  int unsigned    gp, gi, gd, tgt_dist, dpp, drv_min, drv_max;
  logic [12:0]    tgt_head;
  int             speed;
  longint         integ;
  int             prev_err;
  bit             active;

  drive_item_t    pending_items[$];
  drive_result_t  drive_expect[$];
  int             n_queued = 0;
  int             n_checked = 0;
  bit             failed = 1'b0;
  int             idle_mode = 0;
  logic           took = 1'b0;

  function automatic logic [7:0] wheel_clamp(longint w);
    longint lo, hi;
    lo = longint'(drv_min) * 4096;
    hi = longint'(drv_max) * 4096;
    if (w < lo) w = lo;
    else if (w > hi) w = hi;
    return 8'(w >>> 12);
  endfunction

  // one control step of the steering arithmetic
  function automatic drive_result_t steer_predict(drive_item_t it);
    drive_result_t r;
    longint        travel, gap, s, dterm, c, base;
    int            h, e, t;
    r = '{8'd0, 8'd0, 1'b0, 1'b0};
    s = longint'(tgt_dist);
    if (it.kind == KIND_START) begin
      speed  = START_SPEED;
      active = (s != 0);
      r.running = active;
      return r;
    end
    if (!active) return r;
    travel = ((longint'(it.left_pulses) + longint'(it.right_pulses)) * longint'(dpp)) >>> 1;
    gap  = travel > s ? travel - s : s - travel;
    if (gap * 100 < s * 35) speed = (speed >= RAMP_STEP) ? speed - RAMP_STEP : 0;
    h = int'(it.heading);
    if (h > HALF_TURN) h -= FULL_TURN;
    t = $signed(tgt_head);
    e = t - h;
    if (e > HALF_TURN) e -= FULL_TURN;
    else if (e < -HALF_TURN) e += FULL_TURN;
    dterm = 0;
    if (it.elapsed_us != 0)
      dterm = longint'(gd) * longint'(e - prev_err) * MICROS / longint'(it.elapsed_us);
    integ += longint'(e) * longint'(it.elapsed_us);
    if (integ > 64'sd140737488355327) integ = 64'sd140737488355327;
    else if (integ < -64'sd140737488355328) integ = -64'sd140737488355328;
    c = longint'(gp) * e + dterm + (longint'(gi) * integ) / MICROS;
    prev_err = e;
    base = longint'(speed) * 16;
    r.left_drive  = wheel_clamp(base + c);
    r.right_drive = wheel_clamp(base - c);
    if (travel >= s || speed <= STOP_SPEED) begin
      active = 1'b0;
      r.run_done = 1'b1;
    end else begin
      r.running = 1'b1;
    end
    return r;
  endfunction

  // input side: record acceptances and work out the expectation
  always @(posedge clk) begin
    drive_item_t it;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        it.kind         = s_tuser;
        it.heading      = s_tdata[12:0];
        it.right_pulses = s_tdata[32:13];
        it.left_pulses  = s_tdata[52:33];
        it.elapsed_us   = s_tdata[72:53];
        drive_expect.push_back(steer_predict(it));
      end
    end
  end

  // driver: present the next pending item, idling at random
  always @(negedge clk) begin
    drive_item_t it;
    bit          gap_now;
    if (!rst && (!s_tvalid || took)) begin
      gap_now = (idle_mode == 0) ? ($urandom_range(99) < 32) :
                (idle_mode == 1) ? ($urandom_range(99) < 70) : 1'b0;
      if (pending_items.size() != 0 && !gap_now) begin
        it = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {7'd0, it.elapsed_us, it.left_pulses, it.right_pulses, it.heading};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (idle_mode == 0) m_tready <= ($urandom_range(99) >= 70);
    else if (idle_mode == 1) m_tready <= ($urandom_range(99) >= 32);
    else m_tready <= 1'b1;
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    drive_result_t x;
    if (!rst && m_tvalid && m_tready) begin
      n_checked <= n_checked + 1;
      if (drive_expect.size() == 0) begin
        $error("result item with nothing expected");
        failed = 1'b1;
      end else begin
        x = drive_expect.pop_front();
        if (m_tdata[7:0] !== x.left_drive) begin
          $error("left_drive expected %0d got %0d", x.left_drive, m_tdata[7:0]);
          failed = 1'b1;
        end
        if (m_tdata[15:8] !== x.right_drive) begin
          $error("right_drive expected %0d got %0d", x.right_drive, m_tdata[15:8]);
          failed = 1'b1;
        end
        if (m_tuser !== x.running) begin
          $error("running expected %0d got %0d", x.running, m_tuser);
          failed = 1'b1;
        end
        if (m_tlast !== x.run_done) begin
          $error("run_done expected %0d got %0d", x.run_done, m_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic push_item(logic kind, int unsigned h, int unsigned rp, int unsigned lp,
                           int unsigned dt);
    drive_item_t it;
    it.kind         = kind;
    it.heading      = h[12:0];
    it.right_pulses = rp[19:0];
    it.left_pulses  = lp[19:0];
    it.elapsed_us   = dt[19:0];
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_checked != n_queued);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_GAIN_P:    gp       = val & 16'hFFFF;
      CFG_GAIN_I:    gi       = val & 16'hFFFF;
      CFG_GAIN_D:    gd       = val & 16'hFFFF;
      CFG_TGT_HEAD:  tgt_head = val[12:0];
      CFG_TGT_DIST:  tgt_dist = val & 24'hFFFFFF;
      CFG_DIST_PP:   dpp      = val & 16'hFFFF;
      CFG_MIN_DRIVE: drv_min  = val & 8'hFF;
      CFG_MAX_DRIVE: drv_max  = val & 8'hFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random value biased towards both extremes
  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic int unsigned rand_dt();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(20'hFFFFF);
      default: return $urandom_range(50000, 1000);
    endcase
  endfunction

  // heading near the wanted one, now and then anywhere in 13 bits
  function automatic int unsigned rand_heading();
    int base;
    if ($urandom_range(7) == 0) return $urandom_range(13'h1FFF);
    base = $signed(tgt_head);
    base = base + int'($urandom_range(600)) - 300;
    base = ((base % FULL_TURN) + FULL_TURN) % FULL_TURN;
    return base;
  endfunction

  function automatic int unsigned sat20(longint v);
    return (v > 20'hFFFFF) ? 20'hFFFFF : 32'(v);
  endfunction

  // one start item and a run of ticks with rising or frozen pulse counts
  task automatic one_run();
    int unsigned n, lp, rp, step, i;
    bit          freeze;
    lp = 0;
    rp = 0;
    freeze = ($urandom_range(3) == 0);
    n = freeze ? 90 : $urandom_range(40, 5);
    step = (dpp == 0) ? 1000 : 32'((2 * longint'(tgt_dist)) / (longint'(dpp) * n) + 1);
    push_item(KIND_START, rand_heading(), 0, 0, rand_dt());
    for (i = 0; i < n; i++) begin
      if (!(freeze && i > n / 3)) begin
        lp = sat20(longint'(lp) + $urandom_range(step, step / 2));
        rp = sat20(longint'(rp) + $urandom_range(step, step / 2));
      end
      push_item(KIND_TICK, rand_heading(), rp, lp, rand_dt());
    end
  endtask

  initial begin
    int unsigned k, phase_end;
    gp = 883; gi = 23; gd = 256; tgt_head = '0; tgt_dist = 0;
    dpp = 1024; drv_min = 0; drv_max = 255;
    speed = 0; integ = 0; prev_err = 0; active = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: idle run, heading edges, elapsed extremes, restart, late tick
    push_item(KIND_START, 0, 0, 0, 0);
    push_item(KIND_TICK, 100, 5, 5, 1000);
    wait_idle();
    cfg_write(CFG_TGT_DIST, 100000);
    push_item(KIND_START, 0, 0, 0, 0);
    push_item(KIND_TICK, 0, 1, 1, 0);
    push_item(KIND_TICK, 5759, 2, 2, 20'hFFFFF);
    push_item(KIND_TICK, 8191, 3, 3, 1);
    push_item(KIND_TICK, 2880, 4, 4, 1000);
    push_item(KIND_TICK, 2881, 5, 5, 1000);
    push_item(KIND_START, 1440, 0, 0, 0);
    push_item(KIND_TICK, 4320, 60, 60, 2000);
    push_item(KIND_TICK, 0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    push_item(KIND_TICK, 0, 0, 0, 1000);
    wait_idle();
    cfg_write(CFG_TGT_HEAD, 13'h1000);
    cfg_write(CFG_MIN_DRIVE, 200);
    cfg_write(CFG_MAX_DRIVE, 50);
    push_item(KIND_START, 0, 0, 0, 0);
    push_item(KIND_TICK, 2879, 0, 0, 500);
    push_item(KIND_TICK, 8191, 10, 0, 0);
    push_item(KIND_TICK, 0, 20, 20, 20'hFFFFF);

    // random phases, each with a fresh register setting
    while (n_queued < 1600) begin
      wait_idle();
      idle_mode = (n_queued < 533) ? 0 : (n_queued < 1066) ? 1 : 2;
      cfg_write(CFG_GAIN_P, pick(0, 65535));
      cfg_write(CFG_GAIN_I, pick(0, 65535));
      cfg_write(CFG_GAIN_D, pick(0, 65535));
      if ($urandom_range(5) == 0) cfg_write(CFG_TGT_HEAD, $urandom_range(13'h1FFF));
      else cfg_write(CFG_TGT_HEAD, 32'(int'($urandom_range(5760)) - HALF_TURN));
      cfg_write(CFG_TGT_DIST, ($urandom_range(9) == 0) ? 0 : pick(1, 24'hFFFFFF));
      cfg_write(CFG_DIST_PP, pick(0, 65535));
      if ($urandom_range(3) == 0) begin
        cfg_write(CFG_MIN_DRIVE, pick(0, 255));
        cfg_write(CFG_MAX_DRIVE, pick(0, 255));
      end else begin
        cfg_write(CFG_MIN_DRIVE, $urandom_range(40));
        cfg_write(CFG_MAX_DRIVE, $urandom_range(255, 150));
      end
      phase_end = n_queued + 60;
      while (n_queued < phase_end) begin
        if ($urandom_range(9) == 0) begin
          for (k = 0; k < 4; k++)
            push_item(1'($urandom_range(1)), $urandom_range(13'h1FFF),
                      $urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF),
                      $urandom_range(20'hFFFFF));
        end else begin
          one_run();
        end
      end
    end

    wait_idle();
    repeat (300) @(negedge clk);
    if (failed || drive_expect.size() != 0) $display("simulation failed");
    else $display("simulation ok");
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hpsd_pkg.sv
rtl/heading_pid_straight_drive.sv
rtl/hpsd_checker.sv
verif/tb.sv
